// File: hdl/iirl_pkg.sv
package iirl_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 64;
    localparam int ENTRY_BITS_DEF = 32;

    // Fixed field widths of the transfer structs
    localparam int OP_BITS     = 3;
    localparam int POS_BITS    = 7;
    localparam int WORD_BITS   = 32;
    localparam int STAT_BITS   = 2;
    localparam int CNT_BITS    = 7;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_GET    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_POP    = 3'd4;
    localparam logic [OP_BITS-1:0] OP_PEEK   = 3'd5;

    // Status codes
    localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [POS_BITS-1:0]  position;
        logic [WORD_BITS-1:0] entry_in;
    } req_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [WORD_BITS-1:0] entry_out;
        logic [CNT_BITS-1:0]  count;
        logic                 is_empty;
    } rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;       // latch request
        logic init_idx;      // load shift index
        logic rd_fetch;      // read entry to return
        logic rd_shift;      // read neighbor for shift
        logic wr_shift;      // write neighbor one place over
        logic finish_ok;     // apply op, load result
        logic finish_plain;  // load result, no state change
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [STAT_BITS-1:0] dec_status;
        logic                 shift_more;
    } sts_t;

endpackage

// File: hdl/iirl_dpath.sv
module iirl_dpath
    import iirl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output sts_t sts,
    output rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_BITS) ? CW : POS_BITS;

    req_t                  req_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         idx_next;
    logic [ENTRY_BITS-1:0] mem [CAPACITY];
    logic [ENTRY_BITS-1:0] rdata_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic [MW-1:0]         pos_ext;
    logic [MW-1:0]         cnt_ext;
    logic [MW-1:0]         idx_ext;
    logic [MW-1:0]         tgt_ext;
    logic [MW-1:0]         idx_up;
    logic [MW-1:0]         idx_dn;
    logic [MW-1:0]         cnt_dn;
    logic [MW-1:0]         rd_ext;
    logic [MW-1:0]         cnt_new_ext;
    logic                  full;
    logic                  empty;
    logic                  is_remove;
    logic                  is_ins;
    logic [STAT_BITS-1:0]  dec_status;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;

    assign pos_ext   = MW'(req_reg.position);
    assign cnt_ext   = MW'(count_reg);
    assign idx_ext   = MW'(idx_reg);
    assign idx_up    = MW'(idx_ext + MW'(1));
    assign idx_dn    = MW'(idx_ext - MW'(1));
    assign cnt_dn    = MW'(cnt_ext - MW'(1));
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign is_remove = (req_reg.op == OP_REMOVE);
    assign is_ins    = (req_reg.op == OP_INSERT) || (req_reg.op == OP_PUSH);
    // push inserts at the end
    assign tgt_ext   = (req_reg.op == OP_PUSH) ? cnt_ext : pos_ext;

    always_comb
    begin
        dec_status = ST_OK;
        unique case (req_reg.op)
            OP_GET, OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                    dec_status = ST_BAD_INDEX;
            end
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    dec_status = ST_BAD_INDEX;
                else if (full)
                    dec_status = ST_FULL;
            end
            OP_PUSH:
            begin
                if (full)
                    dec_status = ST_FULL;
            end
            OP_POP, OP_PEEK:
            begin
                if (empty)
                    dec_status = ST_EMPTY;
            end
            default:
                dec_status = ST_OK;
        endcase
    end

    assign sts.op         = req_reg.op;
    assign sts.dec_status = dec_status;
    assign sts.shift_more = is_remove ? (idx_up < cnt_ext) : (idx_ext > tgt_ext);

    // Memory port control
    always_comb
    begin
        rd_en = cmd.rd_fetch | cmd.rd_shift;
        if (cmd.rd_shift)
            rd_ext = is_remove ? idx_up : idx_dn;
        else if (req_reg.op == OP_GET)
            rd_ext = pos_ext;
        else
            rd_ext = cnt_dn;
        rd_addr = rd_ext[AW-1:0];

        wr_en   = cmd.wr_shift | (cmd.finish_ok & is_ins);
        wr_addr = idx_ext[AW-1:0];
        wr_data = cmd.wr_shift ? rdata_reg : ENTRY_BITS'(req_reg.entry_in);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Index, count, result
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.init_idx)
            idx_next = is_remove ? pos_ext[CW-1:0] : count_reg;
        else if (cmd.wr_shift)
            idx_next = is_remove ? idx_up[CW-1:0] : idx_dn[CW-1:0];

        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (cmd.finish_ok)
        begin
            rsp_next.status    = ST_OK;
            rsp_next.entry_out = '0;
            unique case (req_reg.op)
                OP_INSERT, OP_PUSH:
                    count_next = CW'(count_reg + CW'(1));
                OP_REMOVE:
                    count_next = CW'(count_reg - CW'(1));
                OP_POP:
                begin
                    count_next         = CW'(count_reg - CW'(1));
                    rsp_next.entry_out = WORD_BITS'(rdata_reg);
                end
                OP_GET, OP_PEEK:
                    rsp_next.entry_out = WORD_BITS'(rdata_reg);
                default:
                    count_next = count_reg;
            endcase
        end
        else if (cmd.finish_plain)
        begin
            rsp_next.status    = dec_status;
            rsp_next.entry_out = '0;
        end
        cnt_new_ext = MW'(count_next);
        if (cmd.finish_ok | cmd.finish_plain)
        begin
            rsp_next.count    = cnt_new_ext[CNT_BITS-1:0];
            rsp_next.is_empty = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

// File: hdl/iirl_ctrl.sv
module iirl_ctrl
    import iirl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FETCH,
        S_SH_CHK,
        S_SH_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.dec_status != ST_OK)
                begin
                    cmd.finish_plain = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    unique case (sts.op)
                        OP_GET, OP_POP, OP_PEEK:
                        begin
                            cmd.rd_fetch = 1'b1;
                            state_next   = S_FETCH;
                        end
                        OP_INSERT, OP_PUSH, OP_REMOVE:
                        begin
                            cmd.init_idx = 1'b1;
                            state_next   = S_SH_CHK;
                        end
                        default:
                        begin
                            cmd.finish_plain = 1'b1;
                            state_next       = S_IDLE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.finish_ok = 1'b1;
                state_next    = S_IDLE;
            end
            S_SH_CHK:
            begin
                if (sts.shift_more)
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = S_SH_WR;
                end
                else
                begin
                    cmd.finish_ok = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SH_CHK;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= cmd.finish_ok | cmd.finish_plain;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: hdl/indexed_insert_remove_list.sv
// Ordered list of up to CAPACITY entry words with get/insert/remove/push/pop/peek
// by command. A request transfers on a clock edge with start high and busy low;
// its single result shows on rsp for exactly one cycle with done high and must be
// taken then, as it cannot be held off. busy drops in the same cycle as done, so a
// new request may transfer while the result is shown. Insert and remove move n
// entries, where n is count - position for insert and count - position - 1 for
// remove. Each moved entry is read and then written back one place over, in
// separate steps. No clearing pass after reset: only entries below the count
// are ever read.
module indexed_insert_remove_list
    import iirl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer: decode, fetch, shift loop
    iirl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Storage, count, index checks and result register
    iirl_dpath
    #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (ENTRY_BITS)
    )
    u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .sts   (sts),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // A result only follows a request in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");

    // An accepted request holds off the next one
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    // Failed requests return no entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.entry_out == '0))
        else $error("failed request returned an entry");

    // Empty flag agrees with the count
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.is_empty) |-> (rsp.count == '0))
        else $error("empty flag with nonzero count");
`endif

endmodule

// File: sim/testbench.sv
module testbench
    import iirl_pkg::*;
();

    // Sizing of the block as instantiated (package defaults)
    localparam int LIST_DEPTH = CAPACITY_DEF;

    // Worst request: insert at 0 into a list one short of full moves every
    // entry. Used for the quiet time at the end of the run.
    localparam int LONGEST_OP = 2 * LIST_DEPTH + 3;

    // Watchdog limit, set well beyond the slowest legal run of roughly 1000 transfers.
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam int RANDOM_SEGMENTS = 10;
    localparam int SEGMENT_ITEMS   = 95;

    // Bias of a random segment
    typedef enum int {GROW, MIXED, SHRINK} seg_mode_t;

    // Unused op codes, sent as noise
    localparam logic [OP_BITS-1:0] OP_NOP6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_NOP7 = 3'd7;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the list, predicts the response of
    // every accepted request, and checks responses in order against it.
    // ------------------------------------------------------------------
    class list_scoreboard;
        logic [WORD_BITS-1:0] entries [LIST_DEPTH];
        int                   cnt;
        rsp_t                 expected_rsp [$];
        int                   failures;

        function new();
            cnt      = 0;
            failures = 0;
        endfunction

        // Insert with shift-up; bad index checked before fullness.
        function logic [STAT_BITS-1:0] insert_entry(int pos, logic [WORD_BITS-1:0] word);
            if (pos > cnt)
                return ST_BAD_INDEX;
            if (cnt >= LIST_DEPTH)
                return ST_FULL;
            for (int i = cnt; i > pos; i--)
                entries[i] = entries[i-1];
            entries[pos] = word;
            cnt++;
            return ST_OK;
        endfunction

        // Called at the edge where a request transfers.
        function void note_request(req_t r);
            rsp_t e;
            int   pos;
            pos         = int'(r.position);
            e.status    = ST_OK;
            e.entry_out = '0;
            case (r.op)
                OP_GET:
                begin
                    if (pos < cnt)
                        e.entry_out = entries[pos];
                    else
                        e.status = ST_BAD_INDEX;
                end
                OP_INSERT: e.status = insert_entry(pos, r.entry_in);
                OP_REMOVE:
                begin
                    if (pos >= cnt)
                        e.status = ST_BAD_INDEX;
                    else
                    begin
                        for (int i = pos; i + 1 < cnt; i++)
                            entries[i] = entries[i+1];
                        cnt--;
                    end
                end
                OP_PUSH: e.status = insert_entry(cnt, r.entry_in);
                OP_POP:
                begin
                    if (cnt == 0)
                        e.status = ST_EMPTY;
                    else
                    begin
                        e.entry_out = entries[cnt-1];
                        cnt--;
                    end
                end
                OP_PEEK:
                begin
                    if (cnt == 0)
                        e.status = ST_EMPTY;
                    else
                        e.entry_out = entries[cnt-1];
                end
                default: ;
            endcase
            e.count    = CNT_BITS'(cnt);
            e.is_empty = (cnt == 0);
            expected_rsp.push_back(e);
        endfunction

        // Called at the edge where a response transfers.
        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response, got status %0d entry %h count %0d empty %0b",
                         $time, got.status, got.entry_out, got.count, got.is_empty);
                failures++;
                return;
            end
            e = expected_rsp.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, e.status, got.status);
                failures++;
            end
            if (got.entry_out !== e.entry_out)
            begin
                $display("%0t: entry_out mismatch, expected %h actual %h",
                         $time, e.entry_out, got.entry_out);
                failures++;
            end
            if (got.count !== e.count)
            begin
                $display("%0t: count mismatch, expected %0d actual %0d",
                         $time, e.count, got.count);
                failures++;
            end
            if (got.is_empty !== e.is_empty)
            begin
                $display("%0t: is_empty mismatch, expected %0b actual %0b",
                         $time, e.is_empty, got.is_empty);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    list_scoreboard sb = new();
    int             cycles = 0;

    always #5 clk = ~clk;

    indexed_insert_remove_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Response side: a result is shown for exactly one cycle and cannot be
    // held off, so it is sampled at the edge that ends its cycle. Outputs
    // read here are pre-edge values since the DUT updates on the same edge.
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
            sb.check_response(rsp);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("indexed_insert_remove_list test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------

    // Present one request until it transfers (start high, busy low at an
    // edge). Each cycle start is dropped at random when idling is allowed,
    // so idle cycles also land where the block could take a request. One
    // assignment to start per edge.
    task automatic send_request(input req_t r, input bit may_idle);
        bit hold;
        req <= r;
        do
        begin
            hold = may_idle && ($urandom_range(0, 99) < 36);
            start <= !hold;
            @(posedge clk);
        end
        while (hold || busy !== 1'b0);
        sb.note_request(r);
    endtask

    // Hold off new requests until every predicted response has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [OP_BITS-1:0] op, input int pos,
                               input logic [WORD_BITS-1:0] word);
        req_t r;
        r.op       = op;
        r.position = POS_BITS'(pos);
        r.entry_in = word;
        send_request(r, 1'b1);
    endtask

    initial
    begin
        req_t      r;
        seg_mode_t mode;
        int        pick;
        int        room;
        bit        idle_ok;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed part: empty-list errors, shifts at front/middle/end,
        // out-of-range positions, unused op codes, drain back to empty.
        send_fields(OP_GET,    0,   32'h0000_0000);  // get on empty
        send_fields(OP_POP,    0,   32'h0000_0000);  // pop on empty
        send_fields(OP_PEEK,   0,   32'h0000_0000);  // peek on empty
        send_fields(OP_REMOVE, 0,   32'h0000_0000);  // remove on empty
        send_fields(OP_INSERT, 1,   32'h1111_1111);  // insert past end
        send_fields(OP_INSERT, 0,   32'hFFFF_FFFF);
        send_fields(OP_PUSH,   127, 32'h0000_0000);  // position ignored
        send_fields(OP_INSERT, 0,   32'hA5A5_5A5A);  // front, shifts all
        send_fields(OP_INSERT, 1,   32'h1234_5678);  // middle
        send_fields(OP_INSERT, 4,   32'h8000_0001);  // at end (== count)
        send_fields(OP_GET,    0,   32'h0000_0000);
        send_fields(OP_GET,    4,   32'h0000_0000);  // last valid
        send_fields(OP_GET,    5,   32'h0000_0000);  // == count, bad
        send_fields(OP_GET,    127, 32'hFFFF_FFFF);
        send_fields(OP_INSERT, 127, 32'hDEAD_BEEF);  // far past end
        send_fields(OP_PEEK,   64,  32'h0000_0000);
        send_fields(OP_REMOVE, 1,   32'h0000_0000);  // middle, shifts down
        send_fields(OP_REMOVE, 3,   32'h0000_0000);  // last, no shift
        send_fields(OP_REMOVE, 64,  32'h0000_0000);  // bad
        send_fields(OP_NOP6,   127, 32'hFFFF_FFFF);
        send_fields(OP_NOP7,   0,   32'h0000_0000);
        send_fields(OP_POP,    0,   32'h0000_0000);
        send_fields(OP_REMOVE, 0,   32'h0000_0000);
        send_fields(OP_POP,    0,   32'h0000_0000);  // back to empty
        wait_drained();

        // --- Random part, in segments biased to fill, churn or drain the list
        // so that full and empty are both reached repeatedly.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       mode = GROW;
                2:       mode = SHRINK;
                default: mode = MIXED;
            endcase
            // One segment runs back to back with no idling.
            idle_ok = (seg != 4);
            // Mid-run pause until the block has nothing outstanding.
            if (seg == 5)
                wait_drained();

            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                case (mode)
                    GROW:
                        r.op = (pick < 45) ? OP_PUSH   : (pick < 85) ? OP_INSERT :
                               (pick < 90) ? OP_GET    : (pick < 94) ? OP_PEEK   :
                               (pick < 97) ? OP_REMOVE : (pick < 99) ? OP_POP    :
                               ($urandom_range(0, 1) ? OP_NOP6 : OP_NOP7);
                    SHRINK:
                        r.op = (pick < 30) ? OP_REMOVE : (pick < 65) ? OP_POP    :
                               (pick < 80) ? OP_GET    : (pick < 90) ? OP_PEEK   :
                               (pick < 95) ? OP_INSERT : (pick < 98) ? OP_PUSH   :
                               ($urandom_range(0, 1) ? OP_NOP6 : OP_NOP7);
                    default:
                        r.op = (pick < 18) ? OP_GET    : (pick < 36) ? OP_INSERT :
                               (pick < 54) ? OP_REMOVE : (pick < 68) ? OP_PUSH   :
                               (pick < 82) ? OP_POP    : (pick < 96) ? OP_PEEK   :
                               ($urandom_range(0, 1) ? OP_NOP6 : OP_NOP7);
                endcase

                // Mostly legal positions against the current count; some fully
                // random to hit bad index and every position bit.
                room = sb.cnt;
                if ($urandom_range(0, 99) < 15)
                    r.position = POS_BITS'($urandom_range(0, 127));
                else if (r.op == OP_INSERT)
                    r.position = POS_BITS'($urandom_range(0, room));
                else if (r.op == OP_GET || r.op == OP_REMOVE)
                    r.position = POS_BITS'((room == 0) ? 0 : $urandom_range(0, room - 1));
                else
                    r.position = POS_BITS'($urandom_range(0, 127));
                r.entry_in = $urandom;

                send_request(r, idle_ok);
            end
        end

        // --- End: everything back, then a quiet stretch so a stray extra
        // response would still be caught.
        wait_drained();
        repeat (LONGEST_OP + 8) @(posedge clk);

        if (sb.failures == 0 && sb.expected_rsp.size() == 0)
            $display("indexed_insert_remove_list test passed");
        else
            $display("indexed_insert_remove_list test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/iirl_pkg.sv
hdl/iirl_dpath.sv
hdl/iirl_ctrl.sv
hdl/indexed_insert_remove_list.sv
sim/testbench.sv
